// ===== rtl/tacr_pkg.sv =====
`timescale 1ns / 1ps
package tacr_pkg;

    localparam int unsigned ADC_W    = 12;
    localparam int unsigned TORQUE_W = 16;
    localparam int unsigned ERR_W    = 32;
    localparam int unsigned PROD_W   = 57;
    localparam int unsigned SUM_W    = 58;

    localparam logic signed [SUM_W-1:0] I_LOW  = SUM_W'(64'sd5 << 24);
    localparam logic signed [SUM_W-1:0] I_HIGH = SUM_W'(64'sd255 << 24);
    localparam logic [19:0] TARGET_MAX = 20'hFFFFF;
    localparam logic [10:0] STEPS_MAX  = 11'h7FF;

    localparam logic [1:0] REQ_TORQUE = 2'd0;
    localparam logic [1:0] REQ_ADC    = 2'd1;
    localparam logic [1:0] REQ_STEP   = 2'd2;

    localparam logic [7:0] CFG_KP     = 8'd0;
    localparam logic [7:0] CFG_KI     = 8'd1;
    localparam logic [7:0] CFG_SLOPE  = 8'd2;
    localparam logic [7:0] CFG_OFFSET = 8'd3;
    localparam logic [7:0] CFG_GATE   = 8'd4;
    localparam logic [7:0] CFG_FLOOR  = 8'd5;
    localparam logic [7:0] CFG_CPT    = 8'd6;
    localparam logic [7:0] CFG_TMO    = 8'd7;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_NEW    = 12'b0000_0000_0010,
        ST_MAX    = 12'b0000_0000_0100,
        ST_MAXEND = 12'b0000_0000_1000,
        ST_MED    = 12'b0000_0001_0000,
        ST_MEDEND = 12'b0000_0010_0000,
        ST_ERR    = 12'b0000_0100_0000,
        ST_MULI   = 12'b0000_1000_0000,
        ST_INTEG  = 12'b0001_0000_0000,
        ST_MULP   = 12'b0010_0000_0000,
        ST_DRV    = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } t_state;

    function automatic logic [31:0] clamp_q24(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        begin
            if (v < I_LOW) begin
                c = I_LOW;
            end else if (v > I_HIGH) begin
                c = I_HIGH;
            end else begin
                c = v;
            end
            clamp_q24 = c[31:0];
        end
    endfunction

endpackage

// ===== rtl/tacr_vmem.sv =====
`timescale 1ns / 1ps
module tacr_vmem #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_q;
    logic             r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_qv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

// ===== rtl/torque_assist_current_regulator.sv =====
`timescale 1ns / 1ps
// channel   direction  contents
// s_axis    in         tuser: req_type; tdata: torque_value, adc_sample
// m_axis    out        tdata: dac_level, assist_target, torque_timeout
// cfg       in         i_cfg_index, i_cfg_data, register write
//
// Torque and ADC requests are taken in the idle state and leave it unchanged.
// A control step holds the input until its result goes to the output register,
// through the window maximum scan (with assist on only) and a 12-bit bitwise
// median search, each pass one read a cycle from memory.
// Reset clears the state, integrator and memory valid bits and loads config defaults.
// A finished result waits in the output register; a new request is taken meanwhile.
module torque_assist_current_regulator
    import tacr_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 100,
    parameter int unsigned SAMPLE_COUNT = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] torque_value, [27:16] adc_sample
    input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] dac_level, [28:8] assist_target,
                                       // [29] torque_timeout
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int unsigned WA    = $clog2(WINDOW_DEPTH);
    localparam int unsigned SA    = $clog2(SAMPLE_COUNT);
    localparam int unsigned CNT_W = (WA > SA) ? WA : SA;
    localparam int unsigned CW    = $clog2(SAMPLE_COUNT + 1);
    localparam int unsigned MED_K = SAMPLE_COUNT / 2 + 1;

    logic [23:0] r_kp, r_ki;
    logic [15:0] r_slope;
    logic [19:0] r_offset;
    logic [14:0] r_gate, r_floor;
    logic [7:0]  r_cpt;
    logic [9:0]  r_tmo;

    t_state r_state, n_state;
    logic [WA-1:0]    r_wpos;
    logic [SA-1:0]    r_spos;
    logic [10:0]      r_steps;
    logic [31:0]      r_integral;
    logic [CNT_W-1:0] r_cnt;
    logic             r_take;
    logic signed [15:0] r_mx;
    logic [3:0]       r_bit;
    logic [ADC_W-1:0] r_med;
    logic [CW-1:0]    r_count;
    logic signed [20:0] r_target;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [PROD_W-1:0] r_prod;
    logic             r_tmo_flag;
    logic [7:0]       r_dac;
    logic             r_ovalid;
    logic [31:0]      r_odata;

    logic in_acc;
    logic [1:0] req;
    logic           w_we, s_we;
    logic [WA-1:0]  w_waddr, w_raddr, w_next;
    logic [SA-1:0]  s_raddr;
    logic [TORQUE_W-1:0] w_rdata;
    logic [ADC_W-1:0]    s_rdata;
    logic signed [15:0]  mx_new;
    logic [ADC_W-1:0]    trial;
    logic                hit;
    logic [CW-1:0]       tot;
    logic [14:0]         mx_f;
    logic [22:0]         tprod;
    logic [28:0]         measured;
    logic signed [SUM_W-1:0] isum, dsum;
    logic [31:0]         drive;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign req    = s_axis_tuser;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign w_next  = (r_wpos == WA'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + WA'(1);
    assign w_we    = in_acc && (req == REQ_TORQUE);
    assign w_waddr = w_next;
    assign w_raddr = (r_state == ST_IDLE) ? r_wpos : r_cnt[WA-1:0];
    assign s_we    = in_acc && (req == REQ_ADC);
    assign s_raddr = r_cnt[SA-1:0];

    tacr_vmem #(.WIDTH(TORQUE_W), .DEPTH(WINDOW_DEPTH)) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[15:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tacr_vmem #(.WIDTH(ADC_W), .DEPTH(SAMPLE_COUNT)) u_samples (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (s_we),
        .i_waddr (r_spos),
        .i_wdata (s_axis_tdata[27:16]),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign mx_new   = (r_take && ($signed(w_rdata) > r_mx)) ? $signed(w_rdata) : r_mx;
    assign trial    = r_med | ((ADC_W'(1) << r_bit) - ADC_W'(1));
    assign hit      = r_take && (s_rdata <= trial);
    assign tot      = r_count + CW'(hit);
    assign mx_f     = (mx_new < $signed({1'b0, r_floor})) ? 15'd0 : mx_new[14:0];
    assign tprod    = mx_f * r_cpt;
    assign measured = 29'(r_med) * 29'(r_slope) + 29'(r_offset);
    assign isum     = $signed({{(SUM_W-32){1'b0}}, r_integral})
                    + SUM_W'(r_prod >>> 8);
    assign dsum     = $signed({{(SUM_W-32){1'b0}}, r_integral})
                    + SUM_W'(r_prod >>> 8);
    assign drive    = clamp_q24(dsum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc && req == REQ_STEP) n_state = ST_NEW;
            ST_NEW:    n_state = ($signed(w_rdata) > $signed({1'b0, r_gate})) ? ST_MAX : ST_MED;
            ST_MAX:    if (r_cnt == CNT_W'(WINDOW_DEPTH - 1)) n_state = ST_MAXEND;
            ST_MAXEND: n_state = ST_MED;
            ST_MED:    if (r_cnt == CNT_W'(SAMPLE_COUNT - 1)) n_state = ST_MEDEND;
            ST_MEDEND: n_state = (r_bit == 4'd0) ? ST_ERR : ST_MED;
            ST_ERR:    n_state = ST_MULI;
            ST_MULI:   n_state = ST_INTEG;
            ST_INTEG:  n_state = ST_MULP;
            ST_MULP:   n_state = ST_DRV;
            ST_DRV:    n_state = ST_OUT;
            ST_OUT:    if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= 24'd16777;
            r_ki     <= 24'd1678;
            r_slope  <= 16'd1364;
            r_offset <= 20'd39639;
            r_gate   <= 15'd5;
            r_floor  <= 15'd150;
            r_cpt    <= 8'd30;
            r_tmo    <= 10'd20;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KP:     r_kp     <= i_cfg_data;
                CFG_KI:     r_ki     <= i_cfg_data;
                CFG_SLOPE:  r_slope  <= i_cfg_data[15:0];
                CFG_OFFSET: r_offset <= i_cfg_data[19:0];
                CFG_GATE:   r_gate   <= i_cfg_data[14:0];
                CFG_FLOOR:  r_floor  <= i_cfg_data[14:0];
                CFG_CPT:    r_cpt    <= i_cfg_data[7:0];
                CFG_TMO:    r_tmo    <= i_cfg_data[9:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wpos     <= '0;
            r_spos     <= '0;
            r_steps    <= '0;
            r_integral <= '0;
            r_ovalid   <= 1'b0;
            r_take     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_take  <= (r_state == ST_MAX) || (r_state == ST_MED);
            if (w_we) begin
                r_wpos  <= w_next;
                r_steps <= '0;
            end
            if (s_we) begin
                r_spos <= (r_spos == SA'(SAMPLE_COUNT - 1)) ? '0 : r_spos + SA'(1);
            end
            if (in_acc && req == REQ_STEP && r_steps != STEPS_MAX) begin
                r_steps <= r_steps + 11'd1;
            end
            if (r_state == ST_INTEG) begin
                r_integral <= clamp_q24(isum);
            end
            if (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_cnt <= '0;
                r_mx  <= 16'sh8000;
            end
            ST_NEW: begin
                r_cnt    <= '0;
                r_target <= -21'sd1;
                r_bit    <= 4'(ADC_W - 1);
                r_med    <= '0;
                r_count  <= '0;
            end
            ST_MAX: begin
                r_mx  <= mx_new;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_MAXEND: begin
                r_target <= $signed({1'b0, (tprod > 23'(TARGET_MAX)) ? TARGET_MAX : tprod[19:0]});
                r_cnt    <= '0;
            end
            ST_MED: begin
                r_count <= tot;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
            ST_MEDEND: begin
                if (tot < CW'(MED_K)) begin
                    r_med <= r_med | (ADC_W'(1) << r_bit);
                end
                r_bit   <= r_bit - 4'd1;
                r_cnt   <= '0;
                r_count <= '0;
            end
            ST_ERR: begin
                r_err      <= (ERR_W'(r_target) <<< 8) - $signed({3'b0, measured});
                r_tmo_flag <= (r_steps > {1'b0, r_tmo});
            end
            ST_MULI: r_prod <= r_err * $signed({1'b0, r_ki});
            ST_INTEG: ;
            ST_MULP: r_prod <= r_err * $signed({1'b0, r_kp});
            ST_DRV:  r_dac  <= (r_target > 21'sd0) ? drive[31:24] : 8'd0;
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_odata <= {2'b0, r_tmo_flag, r_target, r_dac};
                end
            end
            default: ;
        endcase
    end

    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INTEG) |=> (r_integral >= 32'h0500_0000 && r_integral <= 32'hFF00_0000))
        else $error("integrator out of range");

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT))
        else $error("result without step");

    a_med_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MED) |-> (r_cnt < CNT_W'(SAMPLE_COUNT)))
        else $error("median scan overrun");

endmodule

// ===== tb/sv/tb_torque_assist_current_regulator.sv =====
`timescale 1ns / 1ps
module tb_torque_assist_current_regulator
    import tacr_pkg::*;
();

    localparam int WIN = 100;
    localparam int NSAMP = 20;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] torque;
        logic [11:0] adc;
    } t_req;

    typedef struct packed {
        logic [7:0]  dac;
        logic [20:0] target;
        logic        tmo;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    torque_assist_current_regulator dut (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    logic [23:0] kp, ki;
    logic [15:0] slope;
    logic [19:0] offs;
    logic [14:0] gate, flr;
    logic [7:0]  cpt;
    logic [9:0]  tmo_steps;
    logic [15:0] twin [WIN];
    int          wpos;
    logic [11:0] sbuf [NSAMP];
    int          spos;
    logic [31:0] integ;
    int          steps;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   errors;
    int   src_idle, snk_idle;
    bit   hold_off;

    function automatic longint fdiv256(longint x);
        if (x >= 0) return x >>> 8;
        return -((-x + 255) >>> 8);
    endfunction

    function automatic longint clampq(longint v);
        if (v < (longint'(5) << 24)) return longint'(5) << 24;
        if (v > (longint'(255) << 24)) return longint'(255) << 24;
        return v;
    endfunction

    task automatic regulate(input t_req r);
        longint tgt, meas, err, iv, p, drv;
        int mx, v;
        logic [11:0] s [NSAMP];
        logic [11:0] t;
        t_res res;
        case (r.req)
            REQ_TORQUE: begin
                wpos = (wpos + 1) % WIN;
                twin[wpos] = r.torque;
                steps = 0;
            end
            REQ_ADC: begin
                sbuf[spos] = r.adc;
                spos = (spos + 1) % NSAMP;
            end
            REQ_STEP: begin
                if (steps < 2047) steps++;
                res.tmo = steps > int'(tmo_steps);
                if (int'($signed(twin[wpos])) > int'(gate)) begin
                    mx = $signed(twin[0]);
                    for (int k = 1; k < WIN; k++) begin
                        v = $signed(twin[k]);
                        if (v > mx) mx = v;
                    end
                    if (mx < int'(flr)) mx = 0;
                    tgt = longint'(mx) * longint'(cpt);
                    if (tgt > 1048575) tgt = 1048575;
                end else begin
                    tgt = -1;
                end
                s = sbuf;
                for (int a = 0; a < NSAMP; a++)
                    for (int b = 0; b < NSAMP - 1 - a; b++)
                        if (s[b] > s[b+1]) begin
                            t = s[b]; s[b] = s[b+1]; s[b+1] = t;
                        end
                meas = longint'(s[NSAMP/2]) * longint'(slope) + longint'(offs);
                err = tgt * 256 - meas;
                iv = clampq(longint'(integ) + fdiv256(err * longint'(ki)));
                integ = iv[31:0];
                if (tgt > 0) begin
                    p = fdiv256(err * longint'(kp));
                    drv = clampq(p + iv);
                    res.dac = drv[31:24];
                end else begin
                    res.dac = '0;
                end
                res.target = tgt[20:0];
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle) begin
                t_req r;
                r = pending_reqs.pop_front();
                regulate(r);
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= r.req;
                s_axis_tdata  <= {4'b0, r.adc, r.torque};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errors++;
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (m_axis_tdata[7:0] !== e.dac) begin
                        $error("dac_level exp %0d got %0d", e.dac, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[28:8] !== e.target) begin
                        $error("assist_target exp %h got %h", e.target,
                               m_axis_tdata[28:8]);
                        errors++;
                    end
                    if (m_axis_tdata[29] !== e.tmo) begin
                        $error("torque_timeout exp %0d got %0d", e.tmo, m_axis_tdata[29]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KP:     kp = val;
            CFG_KI:     ki = val;
            CFG_SLOPE:  slope = val[15:0];
            CFG_OFFSET: offs = val[19:0];
            CFG_GATE:   gate = val[14:0];
            CFG_FLOOR:  flr = val[14:0];
            CFG_CPT:    cpt = val[7:0];
            CFG_TMO:    tmo_steps = val[9:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_req rand_req(input bit torque_hi);
        t_req r;
        int k;
        k = int'($urandom_range(99));
        r.req = k < 35 ? REQ_TORQUE : k < 65 ? REQ_ADC : k < 97 ? REQ_STEP : REQ_UNUSED;
        r.torque = 16'($urandom);
        if (torque_hi && $urandom_range(3) != 0) r.torque = 16'($urandom_range(32767));
        if ($urandom_range(3) == 0) r.torque = 16'($urandom_range(600));
        r.adc = 12'($urandom);
        return r;
    endfunction

    task automatic push(input logic [1:0] q, input logic [15:0] t, input logic [11:0] a);
        pending_reqs.push_back('{q, t, a});
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        hold_off = 1'b0;
        src_idle = 35;
        snk_idle = 78;
        kp = 16777; ki = 1678; slope = 1364; offs = 39639;
        gate = 5; flr = 150; cpt = 30; tmo_steps = 20;
        foreach (twin[k]) twin[k] = '0;
        foreach (sbuf[k]) sbuf[k] = '0;
        wpos = 0; spos = 0; integ = '0; steps = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        push(REQ_STEP, '0, '0);
        push(REQ_TORQUE, 16'h7FFF, '0);
        push(REQ_ADC, '0, 12'hFFF);
        push(REQ_STEP, '0, '0);
        push(REQ_TORQUE, 16'h8000, 12'hFFF);
        push(REQ_STEP, '0, '0);
        push(REQ_UNUSED, 16'hFFFF, 12'hFFF);
        push(REQ_TORQUE, 16'd100, '0);
        push(REQ_STEP, '0, '0);
        push(REQ_TORQUE, 16'd6, '0);
        push(REQ_STEP, '0, '0);
        push(REQ_TORQUE, 16'd5, '0);
        push(REQ_STEP, '0, '0);
        for (int k = 0; k < 22; k++) push(REQ_STEP, '0, '0);
        drain();

        write_reg(CFG_KP, 24'hFFFFFF);
        write_reg(CFG_KI, 24'hFFFFFF);
        write_reg(CFG_SLOPE, 24'd0);
        write_reg(CFG_OFFSET, 24'd0);
        write_reg(CFG_GATE, 24'd0);
        write_reg(CFG_FLOOR, 24'd0);
        write_reg(CFG_CPT, 24'd255);
        write_reg(CFG_TMO, 24'd1);
        write_reg(8'd200, 24'hABCDEF);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 1) begin
                write_reg(CFG_SLOPE, 24'hFFFF);
                write_reg(CFG_OFFSET, 24'hFFFFF);
                write_reg(CFG_GATE, 24'h7FFF);
                write_reg(CFG_FLOOR, 24'h7FFF);
                write_reg(CFG_TMO, 24'd1023);
                write_reg(CFG_KP, 24'd0);
                write_reg(CFG_KI, 24'd0);
                write_reg(CFG_CPT, 24'd0);
            end else if (ph >= 2) begin
                write_reg(CFG_KP, 24'($urandom_range(2000000)));
                write_reg(CFG_KI, 24'($urandom_range(200000)));
                write_reg(CFG_SLOPE, 24'($urandom_range(3000)));
                write_reg(CFG_OFFSET, 24'($urandom_range(100000)));
                write_reg(CFG_GATE, 24'($urandom_range(300)));
                write_reg(CFG_FLOOR, 24'($urandom_range(1000)));
                write_reg(CFG_CPT, 24'($urandom_range(255)));
                write_reg(CFG_TMO, 24'($urandom_range(40, 1)));
            end
            if (ph == 2) begin
                src_idle = 78; snk_idle = 35;
            end else if (ph >= 4) begin
                src_idle = 0; snk_idle = 0;
            end
            if (ph == 3) begin
                for (int k = 0; k < 30; k++) pending_reqs.push_back(rand_req(1));
                for (int k = 0; k < 8; k++) push(REQ_STEP, '0, '0);
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 100; k++) pending_reqs.push_back(rand_req(ph != 1));
            drain();
        end

        if (errors == 0) begin
            $display("tb_torque_assist_current_regulator OK");
        end else begin
            $display("tb_torque_assist_current_regulator NOT OK");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("tb_torque_assist_current_regulator NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tacr_pkg.sv
rtl/tacr_vmem.sv
rtl/torque_assist_current_regulator.sv
tb/sv/tb_torque_assist_current_regulator.sv
